FILE: src/idct_pkg.sv
// Shared types and constants for the 8x8 inverse DCT block.
// Holds the cosine basis generator and the MAC pipeline tag.
// No dependencies.
package idct_pkg;

	localparam int ROW_BITS    = 18;
	localparam int SAMPLE_BITS = 16;
	localparam int BASIS_W     = 16;
	localparam int OFFSET_BITS = 8;

	// 0.5/sqrt2 at index 0, then 0.5*cos(m*pi/16) for m = 1..7, Q30
	localparam logic [7:0][31:0] HALF_COS_Q30 = {
		32'd104738319, 32'd205451603, 32'd298269498, 32'd379625062,
		32'd446391849, 32'd496004047, 32'd526555088, 32'd379625062
	};

	// basis entry B[n][k] sits at index n*8+k
	typedef logic [63:0][BASIS_W-1:0] basis_tab_t;

	// travels with each product through the MAC
	typedef struct packed {
		logic       vld;
		logic       first;
		logic       last;
		logic       col;
		logic [5:0] pos;
	} mac_tag_t;

	function automatic basis_tab_t basis_table(input int frac);
		basis_tab_t  t;
		int          n;
		int          k;
		int          m;
		logic        neg;
		longint      mag;
		longint      q;
		for (n = 0; n < 8; n++) begin
			for (k = 0; k < 8; k++) begin
				neg = 1'b0;
				if (k == 0) begin
					mag = longint'(HALF_COS_Q30[0]);
				end else begin
					m = ((2 * n + 1) * k) & 31;
					if (m > 16)
						m = 32 - m;
					if (m > 8) begin
						neg = 1'b1;
						m   = 16 - m;
					end
					mag = (m >= 8) ? 64'sd0 : longint'(HALF_COS_Q30[m[2:0]]);
				end
				q = (mag + (longint'(1) << (29 - frac))) >>> (30 - frac);
				t[n * 8 + k] = neg ? BASIS_W'(-q) : BASIS_W'(q);
			end
		end
		return t;
	endfunction

endpackage

FILE: src/idct_ifs.sv
// Handshake channels of the 8x8 inverse DCT block: coefficients in,
// samples out, and the offset register write. No dependencies.
interface idct_coef_if #(parameter int COEF_BITS = 12);
	logic                        valid;
	logic                        ready;
	logic signed [COEF_BITS-1:0] coef;
	modport source (output valid, coef, input ready);
	modport sink (input valid, coef, output ready);
endinterface

interface idct_smp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic [5:0]         position;
	logic               last_of_block;
	modport source (output valid, sample, position, last_of_block, input ready);
	modport sink (input valid, sample, position, last_of_block, output ready);
endinterface

interface idct_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] output_offset;
	modport source (output valid, output_offset, input ready);
	modport sink (input valid, output_offset, output ready);
endinterface

FILE: src/idct_mac.sv
// Shared multiply-accumulate for both passes, with rounding and saturation.
// Depends on idct_pkg.
module idct_mac #(
	parameter int CONST_FRAC_BITS = 13
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  idct_pkg::mac_tag_t                     tag_in,
	input  logic signed [idct_pkg::ROW_BITS-1:0]    op_a,
	input  logic signed [idct_pkg::BASIS_W-1:0]     op_b,
	input  logic [idct_pkg::OFFSET_BITS-1:0]        offset,
	output idct_pkg::mac_tag_t                     tag_out,
	output logic signed [idct_pkg::ROW_BITS-1:0]    row_res,
	output logic signed [idct_pkg::SAMPLE_BITS-1:0] smp_res
);
	import idct_pkg::*;

	localparam int PROD_W = ROW_BITS + BASIS_W;
	localparam int ACC_W  = PROD_W + 4;
	localparam int ROW_SH = CONST_FRAC_BITS - 3;
	localparam int COL_SH = CONST_FRAC_BITS + 3;
	localparam logic signed [ACC_W-1:0] HALF_ROW = ACC_W'(1) << (ROW_SH - 1);
	localparam logic signed [ACC_W-1:0] HALF_COL = ACC_W'(1) << (COL_SH - 1);
	localparam logic signed [ACC_W-1:0] ROW_MAX  = ACC_W'((1 << (ROW_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] ROW_MIN  = -ROW_MAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SMP_MAX  = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SMP_MIN  = -SMP_MAX - ACC_W'(1);

	mac_tag_t                  tag_s2;
	mac_tag_t                  tag_s3;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   off_ext;
	logic signed [ACC_W-1:0]   neg_adj;
	logic signed [ACC_W-1:0]   pre_r;
	logic signed [ACC_W-1:0]   pre_c;
	logic signed [ACC_W-1:0]   rnd_r;
	logic signed [ACC_W-1:0]   rnd_c;

	// column sums start from the offset at the sum's scale
	assign off_ext = $signed(ACC_W'(offset)) <<< COL_SH;

	always_comb begin
		if (tag_s2.first)
			base = tag_s2.col ? off_ext : '0;
		else
			base = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_in;
			// only the closing product of a sum marks a finished result
			tag_s3 <= '{vld: tag_s2.vld & tag_s2.last, first: tag_s2.first,
				last: tag_s2.last, col: tag_s2.col, pos: tag_s2.pos};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= op_a * op_b;
			if (tag_s2.vld)
				acc_q <= base + ACC_W'(prod_s2);
		end
	end

	// half away from zero: add half, less one when negative, then floor
	assign neg_adj = $signed(ACC_W'(acc_q[ACC_W-1]));
	assign pre_r   = acc_q + HALF_ROW - neg_adj;
	assign pre_c   = acc_q + HALF_COL - neg_adj;
	assign rnd_r   = pre_r >>> ROW_SH;
	assign rnd_c   = pre_c >>> COL_SH;

	always_comb begin
		if (rnd_r > ROW_MAX)
			row_res = ROW_BITS'(ROW_MAX);
		else if (rnd_r < ROW_MIN)
			row_res = ROW_BITS'(ROW_MIN);
		else
			row_res = ROW_BITS'(rnd_r);
	end

	always_comb begin
		if (rnd_c > SMP_MAX)
			smp_res = SAMPLE_BITS'(SMP_MAX);
		else if (rnd_c < SMP_MIN)
			smp_res = SAMPLE_BITS'(SMP_MIN);
		else
			smp_res = SAMPLE_BITS'(rnd_c);
	end

	assign tag_out = tag_s3;

endmodule

FILE: src/idct_8x8_block_unit.sv
// 8x8 inverse DCT: 64 items in, 64 samples out per block. A block is loaded,
// then both passes run on the single shared MAC, eight products per result;
// input is refused while the transform runs.
// Reset (arst_n low) clears the control state and the offset; the stores
// are not cleared and need no clearing pass.
module idct_8x8_block_unit #(
	parameter int COEF_BITS       = 12,
	parameter int CONST_FRAC_BITS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	idct_coef_if.sink   coefs,
	idct_smp_if.source  samples,
	idct_cfg_if.sink    cfg
);
	import idct_pkg::*;

	localparam basis_tab_t BASIS = basis_table(CONST_FRAC_BITS);

	// ST_LOAD takes coefficients, ST_RUN sweeps both passes through the MAC
	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                        state_q;
	logic [5:0]                    ld_cnt_q;
	// sweep counter: {column pass, i, j, k}
	logic [9:0]                    cnt_q;
	logic                          cnt_col;
	logic [2:0]                    cnt_i;
	logic [2:0]                    cnt_j;
	logic [2:0]                    cnt_k;
	logic [OFFSET_BITS-1:0]        offset_q;
	logic                          adv;
	logic                          in_acc;

	// the two stores, one write and one registered read port each
	logic signed [COEF_BITS-1:0]   coef_mem [64];
	logic signed [ROW_BITS-1:0]    row_mem  [64];
	logic signed [COEF_BITS-1:0]   coef_rd_q;
	logic signed [ROW_BITS-1:0]    row_rd_q;
	logic signed [BASIS_W-1:0]     basis_s1;
	logic [5:0]                    bidx;
	mac_tag_t                      tag_s0;
	mac_tag_t                      tag_s1;
	mac_tag_t                      tag_done;
	logic signed [ROW_BITS-1:0]    op_a;
	logic signed [ROW_BITS-1:0]    row_res;
	logic signed [SAMPLE_BITS-1:0] smp_res;

	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_smp_q;
	logic [5:0]                    out_pos_q;
	logic                          out_last_q;

	assign {cnt_col, cnt_i, cnt_j, cnt_k} = cnt_q;

	// Whole MAC pipeline freezes while a sample waits in the output register.
	assign adv = !(out_vld_q && !samples.ready);

	assign coefs.ready = (state_q == ST_LOAD);
	assign in_acc      = coefs.valid && coefs.ready;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			offset_q <= '0;
		else if (cfg.valid)
			offset_q <= cfg.output_offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			ld_cnt_q <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						ld_cnt_q <= ld_cnt_q + 6'd1;
						if (ld_cnt_q == 6'd63) begin
							state_q <= ST_RUN;
							cnt_q   <= '0;
						end
					end
				end
				ST_RUN: begin
					if (adv) begin
						cnt_q <= cnt_q + 10'd1;
						if (cnt_q == '1)
							state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Issue: row pass reads coef (i,k) with B[j][k]; column pass reads the
	// row result (k,j) with B[i][k]. A row result passes the read, product
	// and accumulator registers and is written before the column pass first
	// needs it, so no interlock is required on row_mem.
	always_comb begin
		tag_s0.vld   = (state_q == ST_RUN);
		tag_s0.first = (cnt_k == 3'd0);
		tag_s0.last  = (cnt_k == 3'd7);
		tag_s0.col   = cnt_col;
		tag_s0.pos   = {cnt_i, cnt_j};
		bidx         = cnt_col ? {cnt_i, cnt_k} : {cnt_j, cnt_k};
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			coef_mem[ld_cnt_q] <= coefs.coef;
		if (adv) begin
			coef_rd_q <= coef_mem[{cnt_i, cnt_k}];
			row_rd_q  <= row_mem[{cnt_k, cnt_j}];
			basis_s1  <= BASIS[bidx];
		end
		if (adv && tag_done.vld && !tag_done.col)
			row_mem[tag_done.pos] <= row_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s1 <= '0;
		else if (adv)
			tag_s1 <= tag_s0;
	end

	assign op_a = tag_s1.col ? row_rd_q : ROW_BITS'(coef_rd_q);

	idct_mac #(
		.CONST_FRAC_BITS (CONST_FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.tag_in  (tag_s1),
		.op_a    (op_a),
		.op_b    (basis_s1),
		.offset  (offset_q),
		.tag_out (tag_done),
		.row_res (row_res),
		.smp_res (smp_res)
	);

	// output register: parts the MAC from the sample consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv && tag_done.vld && tag_done.col)
			out_vld_q <= 1'b1;
		else if (samples.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && tag_done.vld && tag_done.col) begin
			out_smp_q  <= smp_res;
			out_pos_q  <= tag_done.pos;
			out_last_q <= (tag_done.pos == 6'd63);
		end
	end

	assign samples.valid         = out_vld_q;
	assign samples.sample        = out_smp_q;
	assign samples.position      = out_pos_q;
	assign samples.last_of_block = out_last_q;

	// a finished column result always lands in the output register
	a_col_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tag_done.vld && tag_done.col |=> out_vld_q)
		else $error("column result lost");

	// the 64th coefficient starts the sweep from its beginning
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (ld_cnt_q == 6'd63) |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("sweep did not start cleanly");

	// a stalled finished result is held, not dropped
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && tag_done.vld |=> tag_done.vld && $stable(tag_done.pos))
		else $error("MAC result dropped during stall");

endmodule
